FILE: sv/lrg_pkg.sv
// Shared constants, types and helpers for the line rasterizer grid.
// Used by lrg_walk and line_rasterizer_grid; no dependencies.
`default_nettype none

package lrg_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;

  localparam int COORD_BITS  = 12;
  localparam int BOUND_BITS  = 11;
  localparam int COUNT_BITS  = 13;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int CMP_BITS    = COORD_BITS + 1;
  localparam int CFG_IDX_BITS = 1;

  localparam int CELL_COUNT  = MAX_WIDTH * MAX_HEIGHT;
  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = (CELL_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int CELL_AW     = WORD_AW + BIT_AW;
  localparam int PROD_BITS   = CELL_AW + COORD_BITS;

  localparam logic [BOUND_BITS-1:0] RESET_WIDTH  = BOUND_BITS'(1000);
  localparam logic [BOUND_BITS-1:0] RESET_HEIGHT = BOUND_BITS'(1000);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_RD,
    ST_RDDATA,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_PREP,
    W_RUN
  } walk_state_t;

  // One point of the walk, handed from the stepper to the grid update.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_BITS-1:0] x,
                                                   input logic [COORD_BITS-1:0] y);
    logic [PROD_BITS-1:0] a;
    a = PROD_BITS'(y) * PROD_BITS'(MAX_WIDTH) + PROD_BITS'(x);
    return a[CELL_AW-1:0];
  endfunction

  function automatic logic in_bounds(input logic [COORD_BITS-1:0] x,
                                     input logic [COORD_BITS-1:0] y,
                                     input logic [BOUND_BITS-1:0] w,
                                     input logic [BOUND_BITS-1:0] h);
    logic [CMP_BITS-1:0] xe, ye;
    xe = CMP_BITS'(x);
    ye = CMP_BITS'(y);
    return (xe < CMP_BITS'(w)) && (xe < CMP_BITS'(MAX_WIDTH)) &&
           (ye < CMP_BITS'(h)) && (ye < CMP_BITS'(MAX_HEIGHT));
  endfunction

endpackage

`default_nettype wire

FILE: sv/line_rasterizer_grid.sv
// Top level of the line rasterizer: request FSM, grid memory update and result register.
// Depends on lrg_pkg, lrg_walk and lrg_ram.
`default_nettype none

// The grid lives in one RAM of WORD_COUNT words of WORD_BITS cells (16384 x 64
// for a 1024 x 1024 grid). After reset the block sweeps zeros through every
// word, one word a cycle, and takes no request during the sweep; a clear
// request runs the same sweep and then posts its result. For a draw the
// stepper captures the endpoints, sets up in W_PREP, then emits one point a
// cycle, and each in-bounds point is a read-modify-write on the single RAM
// write port (back-to-back hits on the same word are forwarded). A read issues
// the RAM read in ST_RD and takes the bit in ST_RDDATA. One request is in work
// at a time; a finished result waits in the output register while the next
// request is taken.
module line_rasterizer_grid (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lrg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [lrg_pkg::BOUND_BITS-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_action,
  input  wire logic [lrg_pkg::COORD_BITS-1:0]    in_start_x,
  input  wire logic [lrg_pkg::COORD_BITS-1:0]    in_start_y,
  input  wire logic [lrg_pkg::COORD_BITS-1:0]    in_end_x,
  input  wire logic [lrg_pkg::COORD_BITS-1:0]    in_end_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_occupied,
  output logic [lrg_pkg::COUNT_BITS-1:0]         out_plotted_count
);
  import lrg_pkg::*;

  state_t state_r, state_nxt;

  logic [BOUND_BITS-1:0] grid_width_r, grid_height_r;

  logic                  in_acc;
  action_t               act;
  logic                  walk_start, sweep_en, rd_issue, rd_capture, out_load;
  logic                  sweep_last, sweep_item_r;
  logic [WORD_AW-1:0]    sweep_r;

  point_t                pt;
  logic                  pt_inb;
  logic [CELL_AW-1:0]    pt_addr, in_addr;

  logic                  s1_valid_r;
  logic [WORD_AW-1:0]    s1_word_r;
  logic [BIT_AW-1:0]     s1_bit_r;
  logic                  wr_valid_r;
  logic [WORD_AW-1:0]    wr_word_r;
  logic [WORD_BITS-1:0]  wr_data_r;
  logic [WORD_BITS-1:0]  s1_base, s1_word_new;

  logic                  rd_inb_r;
  logic [WORD_AW-1:0]    rd_word_r;
  logic [BIT_AW-1:0]     rd_bit_r;

  logic                  res_occ_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  out_valid_r;
  logic                  out_occupied_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic                  ram_we, ram_re;
  logic [WORD_AW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  assign act        = action_t'(in_action);
  assign in_acc     = in_valid && !in_stall;
  assign sweep_last = (sweep_r == WORD_AW'(WORD_COUNT - 1));

  assign pt_inb  = pt.valid && in_bounds(pt.x, pt.y, grid_width_r, grid_height_r);
  assign pt_addr = cell_addr(pt.x, pt.y);
  assign in_addr = cell_addr(in_start_x, in_start_y);

  // Config registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RESET_WIDTH;
      grid_height_r <= RESET_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lrg_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_start),
    .sx    (in_start_x),
    .sy    (in_start_y),
    .ex    (in_end_x),
    .ey    (in_end_y),
    .pt    (pt)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sweep_last) state_nxt = sweep_item_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_CLEAR: state_nxt = ST_SWEEP;
            ACT_DRAW:  state_nxt = ST_DRAW;
            ACT_READ:  state_nxt = ST_RD;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DRAW:   if (pt.valid && pt.last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DONE;
      ST_RD:     state_nxt = ST_RDDATA;
      ST_RDDATA: state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall   = 1'b1;
    walk_start = 1'b0;
    sweep_en   = 1'b0;
    rd_issue   = 1'b0;
    rd_capture = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_SWEEP: sweep_en = 1'b1;
      ST_IDLE: begin
        in_stall   = 1'b0;
        walk_start = in_valid && (act == ACT_DRAW);
      end
      ST_RD:     rd_issue   = 1'b1;
      ST_RDDATA: rd_capture = 1'b1;
      ST_DONE:   out_load   = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_r      <= '0;
      sweep_item_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      wr_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      count_r      <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (sweep_en) begin
        sweep_r <= sweep_last ? '0 : sweep_r + WORD_AW'(1);
      end
      if (in_acc) begin
        sweep_item_r <= (act == ACT_CLEAR);
      end
      s1_valid_r <= pt_inb;
      wr_valid_r <= s1_valid_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage 0 issues the read for a point; stage 1 sets the bit and writes back.
  // The word written in the previous cycle is not yet in the read data: forward it.
  assign s1_base     = (wr_valid_r && (wr_word_r == s1_word_r)) ? wr_data_r : ram_rdata;
  assign s1_word_new = s1_base | (WORD_BITS'(1) << s1_bit_r);

  always_ff @(posedge clk) begin
    s1_word_r <= pt_addr[CELL_AW-1:BIT_AW];
    s1_bit_r  <= pt_addr[BIT_AW-1:0];
    wr_word_r <= s1_word_r;
    wr_data_r <= s1_word_new;
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = '0;
    end else if (pt_inb) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_inb_r  <= in_bounds(in_start_x, in_start_y, grid_width_r, grid_height_r);
      rd_word_r <= in_addr[CELL_AW-1:BIT_AW];
      rd_bit_r  <= in_addr[BIT_AW-1:0];
      res_occ_r <= 1'b0;
    end else if (rd_capture) begin
      res_occ_r <= rd_inb_r && ram_rdata[rd_bit_r];
    end
    if (out_load) begin
      out_occupied_r <= res_occ_r;
      out_count_r    <= count_r;
    end
  end

  always_comb begin
    ram_we    = s1_valid_r;
    ram_waddr = s1_word_r;
    ram_wdata = s1_word_new;
    if (sweep_en) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = '0;
    end
    ram_re    = pt_inb || rd_issue;
    ram_raddr = rd_issue ? rd_word_r : pt_addr[CELL_AW-1:BIT_AW];
  end

  lrg_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT),
    .AW    (WORD_AW)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_occupied      = out_occupied_r;
  assign out_plotted_count = out_count_r;

  a_rise_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result posted outside DONE");

  a_points_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    pt.valid |-> state_r == ST_DRAW)
    else $error("stepper emits a point outside a draw");

  a_stage1_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (state_r == ST_DRAW || state_r == ST_DRAIN))
    else $error("grid write pending outside a draw");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !ram_we)
    else $error("grid written while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_BITS'(4096))
    else $error("plotted count beyond one walk");

endmodule

`default_nettype wire

FILE: sv/lrg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old word. No dependencies.
`default_nettype none

module lrg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lrg_walk.sv
// Bresenham stepper: takes two endpoints, emits one grid point per cycle.
// Depends on lrg_pkg.
`default_nettype none

module lrg_walk (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lrg_pkg::COORD_BITS-1:0] sx,
  input  wire logic [lrg_pkg::COORD_BITS-1:0] sy,
  input  wire logic [lrg_pkg::COORD_BITS-1:0] ex,
  input  wire logic [lrg_pkg::COORD_BITS-1:0] ey,
  output lrg_pkg::point_t                     pt
);
  import lrg_pkg::*;

  walk_state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COORD_BITS-1:0] ax_r, ay_r;
  logic                  dx_neg_r, dy_neg_r, dx_zero_r, dy_zero_r;
  logic                  xmaj_r, step_neg_r;
  logic [COORD_BITS-1:0] x_r, y_r, rem_r;
  logic signed [ERR_BITS-1:0] err_r;

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0] ax, ay;
  logic signed [ERR_BITS-1:0] two_ax, two_ay;
  logic                  xmaj;
  logic [COORD_BITS-1:0] minor_step;
  logic                  last;

  assign dx = signed'({1'b0, ex}) - signed'({1'b0, sx});
  assign dy = signed'({1'b0, ey}) - signed'({1'b0, sy});
  assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

  assign two_ax     = signed'({2'b00, ax_r, 1'b0});
  assign two_ay     = signed'({2'b00, ay_r, 1'b0});
  assign xmaj       = (ay_r <= ax_r);
  assign minor_step = step_neg_r ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
  assign last       = (rem_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE:  if (start) state_nxt = W_PREP;
      W_PREP:  state_nxt = W_RUN;
      W_RUN:   if (last) state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_comb begin
    pt.valid = 1'b0;
    pt.last  = 1'b0;
    pt.x     = x_r;
    pt.y     = y_r;
    case (state_r)
      W_RUN: begin
        pt.valid = 1'b1;
        pt.last  = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      W_IDLE: begin
        if (start) begin
          sx_r      <= sx;
          sy_r      <= sy;
          ex_r      <= ex;
          ey_r      <= ey;
          ax_r      <= ax;
          ay_r      <= ay;
          dx_neg_r  <= dx[COORD_BITS];
          dy_neg_r  <= dy[COORD_BITS];
          dx_zero_r <= (dx == '0);
          dy_zero_r <= (dy == '0);
        end
      end
      W_PREP: begin
        xmaj_r     <= xmaj;
        // Minor axis moves up only when both deltas are nonzero with the same sign.
        step_neg_r <= !((dx_neg_r && dy_neg_r) ||
                        (!dx_neg_r && !dx_zero_r && !dy_neg_r && !dy_zero_r));
        if (xmaj) begin
          err_r <= two_ay - signed'(ERR_BITS'(ax_r));
          rem_r <= ax_r;
          x_r   <= dx_neg_r ? ex_r : sx_r;
          y_r   <= dx_neg_r ? ey_r : sy_r;
        end else begin
          err_r <= two_ax - signed'(ERR_BITS'(ay_r));
          rem_r <= ay_r;
          x_r   <= dy_neg_r ? ex_r : sx_r;
          y_r   <= dy_neg_r ? ey_r : sy_r;
        end
      end
      W_RUN: begin
        if (!last) begin
          rem_r <= rem_r - COORD_BITS'(1);
          if (xmaj_r) begin
            x_r <= x_r + COORD_BITS'(1);
            if (err_r < 0) begin
              err_r <= err_r + two_ay;
            end else begin
              y_r   <= y_r + minor_step;
              err_r <= err_r + two_ay - two_ax;
            end
          end else begin
            y_r <= y_r + COORD_BITS'(1);
            if (err_r <= 0) begin
              err_r <= err_r + two_ax;
            end else begin
              x_r   <= x_r + minor_step;
              err_r <= err_r + two_ax - two_ay;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
